[hw/rtl/lru_order_list_defines.svh]
// Assertion macros shared by the LRU order list checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LRU_ORDER_LIST_DEFINES_SVH
`define LRU_ORDER_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define LOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lol_pkg.sv]
// Package for the LRU order list: command, status, microcode and control types.
// No dependencies; imported by every module of the block.
package lol_pkg;

   localparam int ID_W      = 6;
   localparam int OP_W      = 3;
   localparam int ST_W      = 2;
   localparam int OUT_CNT_W = 7;
   localparam int STEP_W    = 5;
   localparam int ACT_W     = 4;
   localparam int COND_W    = 3;

   // Command codes
   localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
   localparam logic [OP_W-1:0] OP_PREPEND    = 3'd1;
   localparam logic [OP_W-1:0] OP_RM_FIRST   = 3'd2;
   localparam logic [OP_W-1:0] OP_RM_LAST    = 3'd3;
   localparam logic [OP_W-1:0] OP_RM_BLOCK   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
   localparam logic [OP_W-1:0] OP_MOVE_END   = 3'd6;
   localparam logic [OP_W-1:0] OP_MOVE_FRONT = 3'd7;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
   localparam logic [ST_W-1:0] ST_PRESENT = 2'd3;

   // Datapath actions, one per microcode step
   localparam logic [ACT_W-1:0] ACT_NOP        = 4'd0;
   localparam logic [ACT_W-1:0] ACT_SEL_HEAD   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_SEL_TAIL   = 4'd2;
   localparam logic [ACT_W-1:0] ACT_SEL_ID     = 4'd3;
   localparam logic [ACT_W-1:0] ACT_UNLINK     = 4'd4;
   localparam logic [ACT_W-1:0] ACT_END1       = 4'd5;
   localparam logic [ACT_W-1:0] ACT_END2       = 4'd6;
   localparam logic [ACT_W-1:0] ACT_FRONT1     = 4'd7;
   localparam logic [ACT_W-1:0] ACT_FRONT2     = 4'd8;
   localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd9;
   localparam logic [ACT_W-1:0] ACT_ST_EMPTY   = 4'd10;
   localparam logic [ACT_W-1:0] ACT_ST_ABSENT  = 4'd11;
   localparam logic [ACT_W-1:0] ACT_ST_PRESENT = 4'd12;

   // Jump conditions
   localparam logic [COND_W-1:0] COND_NONE     = 3'd0;
   localparam logic [COND_W-1:0] COND_BAD      = 3'd1;
   localparam logic [COND_W-1:0] COND_HERE     = 3'd2;
   localparam logic [COND_W-1:0] COND_NOT_HERE = 3'd3;
   localparam logic [COND_W-1:0] COND_EMPTY    = 3'd4;

   // Microcode addresses
   localparam logic [STEP_W-1:0] S_APP0  = 5'd0;
   localparam logic [STEP_W-1:0] S_APP1  = 5'd1;
   localparam logic [STEP_W-1:0] S_APP2  = 5'd2;
   localparam logic [STEP_W-1:0] S_PRE0  = 5'd3;
   localparam logic [STEP_W-1:0] S_PRE1  = 5'd4;
   localparam logic [STEP_W-1:0] S_PRE2  = 5'd5;
   localparam logic [STEP_W-1:0] S_RMF0  = 5'd6;
   localparam logic [STEP_W-1:0] S_RMF1  = 5'd7;
   localparam logic [STEP_W-1:0] S_RMF2  = 5'd8;
   localparam logic [STEP_W-1:0] S_RML0  = 5'd9;
   localparam logic [STEP_W-1:0] S_RML1  = 5'd10;
   localparam logic [STEP_W-1:0] S_RML2  = 5'd11;
   localparam logic [STEP_W-1:0] S_RMB0  = 5'd12;
   localparam logic [STEP_W-1:0] S_RMB1  = 5'd13;
   localparam logic [STEP_W-1:0] S_CLR0  = 5'd14;
   localparam logic [STEP_W-1:0] S_MVE0  = 5'd15;
   localparam logic [STEP_W-1:0] S_MVE1  = 5'd16;
   localparam logic [STEP_W-1:0] S_MVE2  = 5'd17;
   localparam logic [STEP_W-1:0] S_MVE3  = 5'd18;
   localparam logic [STEP_W-1:0] S_MVF0  = 5'd19;
   localparam logic [STEP_W-1:0] S_MVF1  = 5'd20;
   localparam logic [STEP_W-1:0] S_MVF2  = 5'd21;
   localparam logic [STEP_W-1:0] S_MVF3  = 5'd22;
   localparam logic [STEP_W-1:0] S_SEMP  = 5'd23;
   localparam logic [STEP_W-1:0] S_SABS  = 5'd24;
   localparam logic [STEP_W-1:0] S_SPRS  = 5'd25;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ucode_type;

   // Sequencer to datapath
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             finish;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic id_bad;
      logic here;
      logic empty;
   } flags_type;

   function automatic ucode_type uw(input logic [ACT_W-1:0] act,
                                    input logic [COND_W-1:0] cnd,
                                    input logic [STEP_W-1:0] tgt,
                                    input logic lst);
      ucode_type w;
      w.action = act;
      w.cond   = cnd;
      w.target = tgt;
      w.last   = lst;
      return w;
   endfunction

   // Control store: a taken jump suppresses the action of its step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         S_APP0:  w = uw(ACT_NOP,        COND_BAD,      S_SABS, 1'b0);
         S_APP1:  w = uw(ACT_END1,       COND_HERE,     S_SPRS, 1'b0);
         S_APP2:  w = uw(ACT_END2,       COND_NONE,     S_APP0, 1'b1);
         S_PRE0:  w = uw(ACT_NOP,        COND_BAD,      S_SABS, 1'b0);
         S_PRE1:  w = uw(ACT_FRONT1,     COND_HERE,     S_SPRS, 1'b0);
         S_PRE2:  w = uw(ACT_FRONT2,     COND_NONE,     S_APP0, 1'b1);
         S_RMF0:  w = uw(ACT_SEL_HEAD,   COND_EMPTY,    S_SEMP, 1'b0);
         S_RMF1:  w = uw(ACT_NOP,        COND_NONE,     S_APP0, 1'b0);
         S_RMF2:  w = uw(ACT_UNLINK,     COND_NONE,     S_APP0, 1'b1);
         S_RML0:  w = uw(ACT_SEL_TAIL,   COND_EMPTY,    S_SEMP, 1'b0);
         S_RML1:  w = uw(ACT_NOP,        COND_NONE,     S_APP0, 1'b0);
         S_RML2:  w = uw(ACT_UNLINK,     COND_NONE,     S_APP0, 1'b1);
         S_RMB0:  w = uw(ACT_SEL_ID,     COND_NOT_HERE, S_SABS, 1'b0);
         S_RMB1:  w = uw(ACT_UNLINK,     COND_NONE,     S_APP0, 1'b1);
         S_CLR0:  w = uw(ACT_CLEAR,      COND_NONE,     S_APP0, 1'b1);
         S_MVE0:  w = uw(ACT_NOP,        COND_NOT_HERE, S_SABS, 1'b0);
         S_MVE1:  w = uw(ACT_UNLINK,     COND_NONE,     S_APP0, 1'b0);
         S_MVE2:  w = uw(ACT_END1,       COND_NONE,     S_APP0, 1'b0);
         S_MVE3:  w = uw(ACT_END2,       COND_NONE,     S_APP0, 1'b1);
         S_MVF0:  w = uw(ACT_NOP,        COND_NOT_HERE, S_SABS, 1'b0);
         S_MVF1:  w = uw(ACT_UNLINK,     COND_NONE,     S_APP0, 1'b0);
         S_MVF2:  w = uw(ACT_FRONT1,     COND_NONE,     S_APP0, 1'b0);
         S_MVF3:  w = uw(ACT_FRONT2,     COND_NONE,     S_APP0, 1'b1);
         S_SEMP:  w = uw(ACT_ST_EMPTY,   COND_NONE,     S_APP0, 1'b1);
         S_SABS:  w = uw(ACT_ST_ABSENT,  COND_NONE,     S_APP0, 1'b1);
         S_SPRS:  w = uw(ACT_ST_PRESENT, COND_NONE,     S_APP0, 1'b1);
         default: w = uw(ACT_NOP,        COND_NONE,     S_APP0, 1'b1);
      endcase
      return w;
   endfunction

   // Entry point of each command's routine
   function automatic logic [STEP_W-1:0] entry_step(input logic [OP_W-1:0] op);
      logic [STEP_W-1:0] s;
      case (op)
         OP_APPEND:     s = S_APP0;
         OP_PREPEND:    s = S_PRE0;
         OP_RM_FIRST:   s = S_RMF0;
         OP_RM_LAST:    s = S_RML0;
         OP_RM_BLOCK:   s = S_RMB0;
         OP_CLEAR:      s = S_CLR0;
         OP_MOVE_END:   s = S_MVE0;
         OP_MOVE_FRONT: s = S_MVF0;
         default:       s = S_CLR0;
      endcase
      return s;
   endfunction

endpackage

[hw/rtl/lol_seq.sv]
// Microcode sequencer of the LRU order list: step counter, control store, jumps.
// Depends on lol_pkg.
module lol_seq
   import lol_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] opcode,
   input  flags_type       flags,
   input  logic            out_free,
   output ctrl_type        ctrl,
   output logic            busy
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   ucode_type         cw;
   logic              hit;
   logic              jump;
   logic              stall;
   logic              run;

   // Decode current step and its jump condition
   always_comb begin
      cw = ucode_rom(step_ff);
      case (cw.cond)
         COND_NONE:     hit = 1'b0;
         COND_BAD:      hit = flags.id_bad;
         COND_HERE:     hit = flags.here;
         COND_NOT_HERE: hit = !flags.here;
         COND_EMPTY:    hit = flags.empty;
         default:       hit = 1'b0;
      endcase
      jump  = busy_ff && hit;
      // final step waits while the result slot is still occupied
      stall = busy_ff && !jump && cw.last && !out_free;
      run   = busy_ff && !jump && !stall;
      ctrl.action = run ? cw.action : ACT_NOP;
      ctrl.finish = run && cw.last;
   end

   // Step counter
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = entry_step(opcode);
         busy_in = 1'b1;
      end else if (busy_ff && !stall) begin
         step_in = jump ? cw.target : step_ff + STEP_W'(1);
         if (ctrl.finish) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_APP0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

[hw/rtl/lol_dp.sv]
// Datapath of the LRU order list: link memories, presence bits, head, tail, count.
// Depends on lol_pkg; driven by the control word from lol_seq.
module lol_dp
   import lol_pkg::*;
#(
   parameter int NUM_BLOCKS = 64
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ID_W-1:0]      block_id,
   input  ctrl_type             ctrl,
   output flags_type            flags,
   output logic [ID_W-1:0]      removed_nx,
   output logic [ST_W-1:0]      status_nx,
   output logic                 empty_nx,
   output logic [OUT_CNT_W-1:0] count_nx
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   logic [IDX_W-1:0]      b_ff, b_in;
   logic                  valid_ff, valid_in;
   logic [ID_W-1:0]       removed_ff, removed_in;
   logic [ST_W-1:0]       status_ff, status_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NUM_BLOCKS-1:0] present_ff, present_in;

   logic [IDX_W-1:0] next_mem [NUM_BLOCKS];
   logic [IDX_W-1:0] prev_mem [NUM_BLOCKS];
   logic [IDX_W-1:0] next_q, prev_q;

   logic             nx_we, pv_we;
   logic [IDX_W-1:0] nx_addr, nx_data, pv_addr, pv_data;

   logic             at_head, at_tail, is_empty;
   logic [CNT_W-1:0] count_dec;

   assign at_head   = (b_ff == head_ff);
   assign at_tail   = (b_ff == tail_ff);
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - CNT_W'(1);

   // Conditions for the sequencer
   assign flags.id_bad = !valid_ff;
   assign flags.here   = valid_ff && present_ff[b_ff];
   assign flags.empty  = is_empty;

   // Action decode
   always_comb begin
      b_in       = b_ff;
      valid_in   = valid_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      present_in = present_ff;
      nx_we      = 1'b0;
      nx_addr    = b_ff;
      nx_data    = b_ff;
      pv_we      = 1'b0;
      pv_addr    = b_ff;
      pv_data    = b_ff;
      if (start) begin
         b_in       = IDX_W'(block_id);
         valid_in   = (32'(block_id) < NUM_BLOCKS);
         removed_in = '0;
         status_in  = ST_OK;
      end
      case (ctrl.action)
         ACT_SEL_HEAD: begin
            b_in       = head_ff;
            removed_in = ID_W'(head_ff);
         end
         ACT_SEL_TAIL: begin
            b_in       = tail_ff;
            removed_in = ID_W'(tail_ff);
         end
         ACT_SEL_ID: begin
            removed_in = ID_W'(b_ff);
         end
         ACT_UNLINK: begin
            // splice neighbours; an end neighbour points at itself
            nx_we   = !at_head;
            nx_addr = prev_q;
            nx_data = at_tail ? prev_q : next_q;
            pv_we   = !at_tail;
            pv_addr = next_q;
            pv_data = at_head ? next_q : prev_q;
            head_in = at_head ? next_q : head_ff;
            tail_in = at_tail ? prev_q : tail_ff;
            count_in = count_dec;
            present_in[b_ff] = 1'b0;
            if (count_dec == '0) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         ACT_END1: begin
            pv_we = 1'b1;
            if (is_empty) begin
               head_in = b_ff;
               pv_data = b_ff;
            end else begin
               nx_we   = 1'b1;
               nx_addr = tail_ff;
               nx_data = b_ff;
               pv_data = tail_ff;
            end
         end
         ACT_END2: begin
            nx_we    = 1'b1;
            tail_in  = b_ff;
            count_in = count_ff + CNT_W'(1);
            present_in[b_ff] = 1'b1;
         end
         ACT_FRONT1: begin
            nx_we = 1'b1;
            if (is_empty) begin
               tail_in = b_ff;
               nx_data = b_ff;
            end else begin
               pv_we   = 1'b1;
               pv_addr = head_ff;
               pv_data = b_ff;
               nx_data = head_ff;
            end
         end
         ACT_FRONT2: begin
            pv_we    = 1'b1;
            head_in  = b_ff;
            count_in = count_ff + CNT_W'(1);
            present_in[b_ff] = 1'b1;
         end
         ACT_CLEAR: begin
            present_in = '0;
            count_in   = '0;
            head_in    = '0;
            tail_in    = '0;
         end
         ACT_ST_EMPTY:   status_in = ST_EMPTY;
         ACT_ST_ABSENT:  status_in = ST_ABSENT;
         ACT_ST_PRESENT: status_in = ST_PRESENT;
         default: ;
      endcase
   end

   // List state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         present_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         present_ff <= present_in;
         valid_ff   <= valid_in;
      end
   end

   // Request payload
   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   // Link memories: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_addr] <= nx_data;
      end
      next_q <= next_mem[b_ff];
   end

   always_ff @(posedge clock) begin
      if (pv_we) begin
         prev_mem[pv_addr] <= pv_data;
      end
      prev_q <= prev_mem[b_ff];
   end

   assign removed_nx = removed_in;
   assign status_nx  = status_in;
   assign empty_nx   = (count_in == '0);
   assign count_nx   = OUT_CNT_W'(count_in);

endmodule

[hw/rtl/lru_order_list.sv]
// LRU order list: a doubly linked list of block numbers kept in recency order,
// worked by a small microcode sequencer. One request is taken at a time; req_tready
// drops for the routine's steps and returns the cycle after the last one. The
// number of steps is set by the next and previous link memories, each of which
// takes one write per cycle and gives its read data from a register. Results
// leave through a one-entry output register, so a new request is taken while a
// result waits; the last step of a routine holds until that register is free.
// Block numbers at or above NUM_BLOCKS are treated as absent. Depends on lol_pkg,
// lol_seq, lol_dp.
module lru_order_list
   import lol_pkg::*;
#(
   parameter int NUM_BLOCKS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[2:0], block_id[8:3], zero[15:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // removed_block[5:0], status[7:6],
                                    // is_empty[8], entry_count[15:9]
);

   logic                 req_accept;
   logic [OP_W-1:0]      req_opcode;
   logic [ID_W-1:0]      req_block_id;
   logic                 busy;
   logic                 out_free;
   ctrl_type             ctrl;
   flags_type            flags;
   logic [ID_W-1:0]      removed_nx;
   logic [ST_W-1:0]      status_nx;
   logic                 empty_nx;
   logic [OUT_CNT_W-1:0] count_nx;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   assign req_opcode   = req_tdata[2:0];
   assign req_block_id = req_tdata[8:3];
   assign req_tready   = !busy;
   assign req_accept   = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   lol_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .opcode   (req_opcode),
      .flags    (flags),
      .out_free (out_free),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   lol_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .block_id   (req_block_id),
      .ctrl       (ctrl),
      .flags      (flags),
      .removed_nx (removed_nx),
      .status_nx  (status_nx),
      .empty_nx   (empty_nx),
      .count_nx   (count_nx)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {count_nx, empty_nx, status_nx, removed_nx};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/lol_checker.sv]
// Port-level checker for the LRU order list, bound to the top level.
// Depends on lol_pkg, lru_order_list_defines.svh and lru_order_list.
`include "lru_order_list_defines.svh"

module lol_checker
   import lol_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata    // removed_block[5:0], status[7:6],
                                   // is_empty[8], entry_count[15:9]
);

   logic                 req_take;
   logic                 rsp_stall;
   logic                 rsp_fail;
   logic [ID_W-1:0]      rsp_removed;
   logic [ST_W-1:0]      rsp_status;
   logic                 rsp_empty;
   logic [OUT_CNT_W-1:0] rsp_count;

   // Response fields and handshake terms
   assign req_take    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_removed = rsp_tdata[5:0];
   assign rsp_status  = rsp_tdata[7:6];
   assign rsp_empty   = rsp_tdata[8];
   assign rsp_count   = rsp_tdata[15:9];
   assign rsp_fail    = rsp_tvalid && (rsp_status != ST_OK);

   // a stalled result holds
   `LOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "held result moved")

   // empty flag agrees with the count
   `LOL_ASSERT_NOW(a_empty_count, clock, reset, rsp_tvalid, rsp_empty == (rsp_count == '0), "empty vs count")

   // a refused command removes nothing
   `LOL_ASSERT_NOW(a_fail_no_removal, clock, reset, rsp_fail, rsp_removed == '0, "removal on refusal")

   // one request at a time
   `LOL_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_tready, "request taken while busy")

endmodule

bind lru_order_list lol_checker u_lol_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/lru_order_list_check.sv]
// Checker for the LRU order list: follows the request and response streams,
// keeps its own copy of the linked list and compares every response with the one it predicts.
// Depends on lol_pkg for the command and status codes.
`timescale 1ns / 1ps

module lru_order_list_check
   import lol_pkg::*;
#(
   parameter int NUM_BLOCKS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[2:0], block_id[8:3], zero[15:9]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // removed_block[5:0], status[7:6],
                                    // is_empty[8], entry_count[15:9]
   output int          fail_count,
   output int          awaited
);

   // Same bit layout as rsp_tdata, top field first
   typedef struct packed {
      logic [OUT_CNT_W-1:0] count;
      logic                 is_empty;
      logic [ST_W-1:0]      status;
      logic [ID_W-1:0]      removed;
   } list_reply_type;

   // Shadow copy of the list
   logic [ID_W-1:0]      next_of [NUM_BLOCKS];
   logic [ID_W-1:0]      prev_of [NUM_BLOCKS];
   bit                   in_list [NUM_BLOCKS];
   logic [ID_W-1:0]      first_blk;
   logic [ID_W-1:0]      last_blk;
   logic [OUT_CNT_W-1:0] n_blocks;
   list_reply_type       replies_due [$];

   initial fail_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic link_last(input logic [ID_W-1:0] b);
      if (n_blocks == 0) begin
         first_blk  = b;
         prev_of[b] = b;
      end else begin
         next_of[last_blk] = b;
         prev_of[b]        = last_blk;
      end
      next_of[b] = b;
      last_blk   = b;
      in_list[b] = 1'b1;
      n_blocks++;
   endtask

   task automatic link_first(input logic [ID_W-1:0] b);
      if (n_blocks == 0) begin
         last_blk   = b;
         next_of[b] = b;
      end else begin
         prev_of[first_blk] = b;
         next_of[b]         = first_blk;
      end
      prev_of[b] = b;
      first_blk  = b;
      in_list[b] = 1'b1;
      n_blocks++;
   endtask

   task automatic unlink(input logic [ID_W-1:0] b);
      logic [ID_W-1:0] p;
      logic [ID_W-1:0] n;
      bit              at_head;
      bit              at_tail;
      p       = prev_of[b];
      n       = next_of[b];
      at_head = (b == first_blk);
      at_tail = (b == last_blk);
      if (at_head) begin
         first_blk  = n;
         prev_of[n] = n;
      end else begin
         next_of[p] = at_tail ? p : n;
      end
      if (at_tail) begin
         last_blk   = p;
         next_of[p] = p;
      end else if (!at_head) begin
         prev_of[n] = p;
      end
      in_list[b] = 1'b0;
      n_blocks--;
      // an emptied list parks both ends at block zero
      if (n_blocks == 0) begin
         first_blk = '0;
         last_blk  = '0;
      end
   endtask

   // Applies one command to the shadow list and gives the response it should cause
   task automatic run_list_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] raw_id,
                                   output list_reply_type reply);
      bit              id_ok;
      bit              here;
      logic [ID_W-1:0] b;
      id_ok  = int'(raw_id) < NUM_BLOCKS;
      b      = id_ok ? raw_id : '0;
      here   = id_ok && in_list[b];
      reply  = '0;
      reply.status = ST_OK;
      case (op)
         OP_APPEND, OP_PREPEND: begin
            if (!id_ok)
               reply.status = ST_ABSENT;
            else if (here)
               reply.status = ST_PRESENT;
            else if (op == OP_APPEND)
               link_last(b);
            else
               link_first(b);
         end
         OP_RM_FIRST, OP_RM_LAST: begin
            if (n_blocks == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.removed = (op == OP_RM_FIRST) ? first_blk : last_blk;
               unlink(reply.removed);
            end
         end
         OP_RM_BLOCK: begin
            if (!here) begin
               reply.status = ST_ABSENT;
            end else begin
               reply.removed = b;
               unlink(b);
            end
         end
         OP_CLEAR: begin
            foreach (in_list[i]) in_list[i] = 1'b0;
            n_blocks  = '0;
            first_blk = '0;
            last_blk  = '0;
         end
         default: begin
            // move to end or to front
            if (!here) begin
               reply.status = ST_ABSENT;
            end else begin
               unlink(b);
               if (op == OP_MOVE_END)
                  link_last(b);
               else
                  link_first(b);
            end
         end
      endcase
      reply.is_empty = (n_blocks == 0);
      reply.count    = n_blocks;
   endtask

   // Responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin : watch_streams
      list_reply_type seen;
      list_reply_type want;
      if (reset) begin
         foreach (in_list[i]) begin
            in_list[i] = 1'b0;
            next_of[i] = '0;
            prev_of[i] = '0;
         end
         first_blk = '0;
         last_blk  = '0;
         n_blocks  = '0;
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (replies_due.size() == 0) begin
               report_mismatch("response with no request waiting", int'(rsp_tdata), 0);
            end else begin
               want = replies_due.pop_front();
               if (seen.removed !== want.removed)
                  report_mismatch("removed_block", int'(seen.removed), int'(want.removed));
               if (seen.status !== want.status)
                  report_mismatch("status", int'(seen.status), int'(want.status));
               if (seen.is_empty !== want.is_empty)
                  report_mismatch("is_empty", int'(seen.is_empty), int'(want.is_empty));
               if (seen.count !== want.count)
                  report_mismatch("entry_count", int'(seen.count), int'(want.count));
            end
         end
         if (req_tvalid && req_tready) begin
            run_list_command(req_tdata[OP_W-1:0], req_tdata[OP_W+ID_W-1:OP_W], want);
            replies_due.push_back(want);
         end
      end
      awaited = replies_due.size();
   end

endmodule

[tb/lru_order_list_test.sv]
// Testbench top for the LRU order list: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Depends on lol_pkg, lru_order_list and
// lru_order_list_check, which predicts and compares the responses.
`timescale 1ns / 1ps

module lru_order_list_test;
   import lol_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int ITEM_TARGET = 1450;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // opcode[2:0], block_id[8:3], zero[15:9]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // removed_block[5:0], status[7:6],
                             // is_empty[8], entry_count[15:9]
   int          fail_count;
   int          awaited;
   int          items_sent;
   int          quiet_cycles;
   bit          idle_on;
   bit          hold_request;

   lru_order_list #(.NUM_BLOCKS(64)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lru_order_list_check #(.NUM_BLOCKS(64)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .awaited    (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= !idle_on || ($urandom_range(0, 99) >= 19);
      end
   end

   // Watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offers one request, with a random gap first, and returns once it is taken
   task automatic send_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
      while (idle_on && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Stops offering until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // Mixed commands on block numbers drawn from a window of the given size
   task automatic random_episode(input int length, input int pool);
      logic [ID_W-1:0] base;
      logic [OP_W-1:0] op;
      int              r;
      base = ID_W'($urandom_range(0, 63));
      repeat (length) begin
         r = $urandom_range(0, 99);
         if (r < 22)      op = OP_APPEND;
         else if (r < 40) op = OP_PREPEND;
         else if (r < 52) op = OP_MOVE_END;
         else if (r < 64) op = OP_MOVE_FRONT;
         else if (r < 74) op = OP_RM_BLOCK;
         else if (r < 84) op = OP_RM_FIRST;
         else if (r < 97) op = OP_RM_LAST;
         else             op = OP_CLEAR;
         send_command(op, base + ID_W'($urandom_range(0, pool - 1)));
      end
   endtask

   // Fills the list with all 64 blocks in random order, works it, then empties it
   task automatic fill_and_drain();
      logic [ID_W-1:0] order [64];
      logic [ID_W-1:0] swap;
      int              j;
      send_command(OP_CLEAR, ID_W'($urandom_range(0, 63)));
      for (int i = 0; i < 64; i++) order[i] = ID_W'(i);
      for (int i = 63; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < 64; i++)
         send_command($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND, order[i]);
      random_episode(60, 64);
      repeat (66)
         send_command($urandom_range(0, 1) ? OP_RM_FIRST : OP_RM_LAST,
                      ID_W'($urandom_range(0, 63)));
   endtask

   initial begin
      int ep;
      int pool;
      int r;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      items_sent   = 0;
      quiet_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, single block, duplicates, both ends
      send_command(OP_RM_FIRST,   6'd0);
      send_command(OP_RM_LAST,    6'd63);
      send_command(OP_RM_BLOCK,   6'd0);
      send_command(OP_MOVE_END,   6'd63);
      send_command(OP_MOVE_FRONT, 6'd0);
      send_command(OP_CLEAR,      6'd42);
      send_command(OP_APPEND,     6'd0);
      send_command(OP_MOVE_END,   6'd0);
      send_command(OP_MOVE_FRONT, 6'd0);
      send_command(OP_APPEND,     6'd0);
      send_command(OP_APPEND,     6'd63);
      send_command(OP_PREPEND,    6'd42);
      send_command(OP_PREPEND,    6'd63);
      send_command(OP_MOVE_FRONT, 6'd63);
      send_command(OP_MOVE_END,   6'd42);
      send_command(OP_RM_BLOCK,   6'd0);
      send_command(OP_RM_FIRST,   6'd21);
      send_command(OP_RM_LAST,    6'd21);
      send_command(OP_PREPEND,    6'd21);
      send_command(OP_APPEND,     6'd1);
      send_command(OP_RM_BLOCK,   6'd21);
      send_command(OP_CLEAR,      6'd0);
      send_command(OP_RM_LAST,    6'd0);
      send_command(OP_PREPEND,    6'd63);
      send_command(OP_RM_BLOCK,   6'd63);
      drain_responses();

      // Full list while the response side holds off, so the block backs up
      hold_request = 1'b1;
      fill_and_drain();
      drain_responses();

      // Random episodes, mostly on small windows so blocks are often present
      ep = 0;
      while (items_sent < ITEM_TARGET) begin
         idle_on = !(items_sent >= 650 && items_sent < 900);
         r = $urandom_range(0, 9);
         if (r < 4)      pool = 4;
         else if (r < 7) pool = 10;
         else if (r < 9) pool = 24;
         else            pool = 64;
         if (ep == 8)
            fill_and_drain();
         else
            random_episode($urandom_range(20, 60), pool);
         if (ep % 4 == 3)
            drain_responses();
         ep++;
      end

      drain_responses();
      repeat (12) @(posedge clock);
      if (fail_count == 0 && awaited == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lol_pkg.sv
hw/rtl/lol_seq.sv
hw/rtl/lol_dp.sv
hw/rtl/lru_order_list.sv
hw/rtl/lol_checker.sv
tb/lru_order_list_check.sv
tb/lru_order_list_test.sv
